>>> design/bfs_pkg.sv
// Shared types and codes for the breadth-first path finder.
// Holds the field widths and the operation, status and controller state encodings.
// No dependencies; used by design/bfs_path_finder.sv and the testbench.
`default_nettype none

package bfs_pkg;

  // Field widths fixed by the external interface.
  localparam int unsigned VERTEX_W = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SLOT_W   = 3;

  // Request operations.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_FIND  = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_EDGE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NO_PATH = 3'd2,
    ST_FULL    = 3'd3,
    ST_BAD     = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DEQ,
    S_DEG,
    S_NB,
    S_CHECK,
    S_WALK_RD,
    S_WALK,
    S_EMIT_RD,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> design/bfs_path_finder.sv
// Breadth-first shortest path finder over a directed graph kept in memories.
// Depends on bfs_pkg (design/bfs_pkg.sv) for codes and state encoding.
//
//   channel | signals                                 | direction
//   in      | in_valid/in_ready, operation, vertices   | request in
//   out     | out_valid/out_ready, status, edge fields | result out
//   cfg     | cfg_valid/cfg_ready, cfg_data            | register write in
//
// Clear and add-edge finish in S_EXEC. A path query runs S_POP, S_DEQ and
// S_DEG per dequeued vertex and S_NB per scanned edge, then per path edge
// S_WALK_RD/S_WALK walk the parent chain back and S_EMIT_RD/S_EMIT emit. The
// single neighbor memory read port, one entry per cycle, paces the search.
// Reset is synchronous and clears control state only; no clearing pass.
// A full output register stalls the controller in whichever state loads it.
`default_nettype none

module bfs_path_finder #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 8
) (
  input  wire  logic       clk,
  input  wire  logic       rst,
  input  wire  logic       in_valid,
  output logic             in_ready,
  input  wire  logic [1:0] operation,
  input  wire  logic [5:0] from_vertex,
  input  wire  logic [5:0] to_vertex,
  output logic             out_valid,
  input  wire  logic       out_ready,
  output logic [2:0]       status,
  output logic [5:0]       edge_from,
  output logic [5:0]       edge_to,
  output logic [2:0]       edge_slot,
  output logic             last,
  input  wire  logic       cfg_valid,
  output logic             cfg_ready,
  input  wire  logic [6:0] cfg_data
);

  localparam int VW       = $clog2(MAX_VERTICES);
  localparam int QW       = $clog2(MAX_VERTICES + 1);
  localparam int DCW      = $clog2(MAX_DEGREE + 1);
  localparam int SW       = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int NB_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int NAW      = $clog2(NB_DEPTH);
  localparam int PW       = VW + SW;
  localparam int PTW      = 2 * VW + SW;

  // Control and working registers.
  bfs_pkg::state_t state, state_next;
  bfs_pkg::op_t    op_r;
  logic [5:0]      a_r, b_r;
  logic [6:0]      vcount;
  logic [QW-1:0]   head, tail;
  logic [VW-1:0]   u_r, walk_v, cnt;
  logic [DCW-1:0]  deg_r, slot;
  logic [MAX_VERTICES-1:0] visited, deg_valid;

  // Memory ports.
  logic [DCW-1:0] deg_mem [MAX_VERTICES];
  logic           deg_rd_en, deg_wr_en, deg_hit;
  logic [VW-1:0]  deg_rd_addr, deg_wr_addr;
  logic [DCW-1:0] deg_q, deg_wr_data, deg_eff;

  logic [VW-1:0]  nb_mem [NB_DEPTH];
  logic           nb_rd_en, nb_wr_en;
  logic [NAW-1:0] nb_rd_addr, nb_wr_addr;
  logic [VW-1:0]  nb_q;

  logic [PW-1:0]  pa_mem [MAX_VERTICES];
  logic           pa_rd_en, pa_wr_en;
  logic [VW-1:0]  pa_rd_addr, pa_wr_addr;
  logic [PW-1:0]  pa_q, pa_wr_data;

  logic [VW-1:0]  q_mem [MAX_VERTICES];
  logic           q_rd_en, q_wr_en;
  logic [VW-1:0]  q_rd_addr, q_wr_addr, q_q, q_wr_data;

  logic [PTW-1:0] pt_mem [MAX_VERTICES];
  logic           pt_rd_en, pt_wr_en;
  logic [VW-1:0]  pt_rd_addr, pt_wr_addr;
  logic [PTW-1:0] pt_q, pt_wr_data;

  // Combinational control.
  logic             out_free, out_load, deg_clear, search_start, visit;
  logic [DCW-1:0]   nb_rd_slot;
  logic [2:0]       status_next;
  logic [5:0]       edge_from_next, edge_to_next;
  logic [2:0]       edge_slot_next;
  logic             last_next;
  logic             bad;
  logic [VW-1:0]    a_idx, b_idx;
  logic [6:0]       cfg_clamped;

  assign a_idx     = a_r[VW-1:0];
  assign b_idx     = b_r[VW-1:0];
  assign bad       = ({1'b0, a_r} >= vcount) || ({1'b0, b_r} >= vcount);
  assign deg_eff   = deg_hit ? deg_q : '0;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign visit     = (7'(nb_q) < vcount) && !visited[nb_q] &&
                     (tail < QW'(MAX_VERTICES));

  // Register write clamps the vertex count into its legal range.
  always_comb begin
    if (cfg_data == 7'd0) begin
      cfg_clamped = 7'd1;
    end else if (cfg_data > 7'(MAX_VERTICES)) begin
      cfg_clamped = 7'(MAX_VERTICES);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  // Next state, memory accesses and result formation.
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    deg_clear      = 1'b0;
    search_start   = 1'b0;
    status_next    = bfs_pkg::ST_DONE;
    edge_from_next = '0;
    edge_to_next   = '0;
    edge_slot_next = '0;
    last_next      = 1'b1;
    deg_rd_en      = 1'b0;
    deg_rd_addr    = u_r;
    deg_wr_en      = 1'b0;
    deg_wr_addr    = a_idx;
    deg_wr_data    = DCW'(deg_eff + 1'b1);
    nb_rd_en       = 1'b0;
    nb_rd_slot     = '0;
    nb_wr_en       = 1'b0;
    nb_wr_addr     = NAW'(a_idx * MAX_DEGREE) + NAW'(deg_eff);
    pa_rd_en       = 1'b0;
    pa_rd_addr     = walk_v;
    pa_wr_en       = 1'b0;
    pa_wr_addr     = nb_q;
    pa_wr_data     = {u_r, SW'(slot)};
    q_rd_en        = 1'b0;
    q_rd_addr      = head[VW-1:0];
    q_wr_en        = 1'b0;
    q_wr_addr      = tail[VW-1:0];
    q_wr_data      = nb_q;
    pt_rd_en       = 1'b0;
    pt_rd_addr     = VW'(cnt - 1'b1);
    pt_wr_en       = 1'b0;
    pt_wr_addr     = cnt;
    pt_wr_data     = {pa_q[PW-1:SW], walk_v, pa_q[SW-1:0]};
    case (state)
      bfs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          deg_rd_en   = 1'b1;
          deg_rd_addr = from_vertex[VW-1:0];
          state_next  = bfs_pkg::S_EXEC;
        end
      end
      bfs_pkg::S_EXEC: begin
        case (op_r)
          bfs_pkg::OP_CLEAR: begin
            if (out_free) begin
              out_load   = 1'b1;
              deg_clear  = 1'b1;
              state_next = bfs_pkg::S_IDLE;
            end
          end
          bfs_pkg::OP_ADD: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = bfs_pkg::S_IDLE;
              if (bad) begin
                status_next = bfs_pkg::ST_BAD;
              end else if (deg_eff >= DCW'(MAX_DEGREE)) begin
                status_next = bfs_pkg::ST_FULL;
              end else begin
                deg_wr_en = 1'b1;
                nb_wr_en  = 1'b1;
              end
            end
          end
          bfs_pkg::OP_FIND: begin
            if (bad || a_r == b_r) begin
              if (out_free) begin
                out_load    = 1'b1;
                status_next = bad ? bfs_pkg::ST_BAD : bfs_pkg::ST_DONE;
                state_next  = bfs_pkg::S_IDLE;
              end
            end else begin
              search_start = 1'b1;
              q_wr_en      = 1'b1;
              q_wr_addr    = '0;
              q_wr_data    = a_idx;
              state_next   = bfs_pkg::S_POP;
            end
          end
          default: begin
            state_next = bfs_pkg::S_IDLE;
          end
        endcase
      end
      bfs_pkg::S_POP: begin
        if (head == tail) begin
          state_next = bfs_pkg::S_CHECK;
        end else begin
          q_rd_en    = 1'b1;
          state_next = bfs_pkg::S_DEQ;
        end
      end
      bfs_pkg::S_DEQ: begin
        if (q_q == b_idx) begin
          state_next = bfs_pkg::S_CHECK;
        end else begin
          deg_rd_en   = 1'b1;
          deg_rd_addr = q_q;
          state_next  = bfs_pkg::S_DEG;
        end
      end
      bfs_pkg::S_DEG: begin
        if (deg_eff == '0) begin
          state_next = bfs_pkg::S_POP;
        end else begin
          nb_rd_en   = 1'b1;
          state_next = bfs_pkg::S_NB;
        end
      end
      bfs_pkg::S_NB: begin
        // Mark and enqueue a fresh neighbor while the next entry is fetched.
        pa_wr_en = visit;
        q_wr_en  = visit;
        if (DCW'(slot + 1'b1) < deg_r) begin
          nb_rd_en   = 1'b1;
          nb_rd_slot = DCW'(slot + 1'b1);
        end else begin
          state_next = bfs_pkg::S_POP;
        end
      end
      bfs_pkg::S_CHECK: begin
        if (!visited[b_idx]) begin
          if (out_free) begin
            out_load    = 1'b1;
            status_next = bfs_pkg::ST_NO_PATH;
            state_next  = bfs_pkg::S_IDLE;
          end
        end else begin
          state_next = bfs_pkg::S_WALK_RD;
        end
      end
      bfs_pkg::S_WALK_RD: begin
        if (walk_v == a_idx) begin
          state_next = bfs_pkg::S_EMIT_RD;
        end else begin
          pa_rd_en   = 1'b1;
          state_next = bfs_pkg::S_WALK;
        end
      end
      bfs_pkg::S_WALK: begin
        pt_wr_en   = 1'b1;
        state_next = bfs_pkg::S_WALK_RD;
      end
      bfs_pkg::S_EMIT_RD: begin
        pt_rd_en   = 1'b1;
        state_next = bfs_pkg::S_EMIT;
      end
      bfs_pkg::S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          status_next    = bfs_pkg::ST_EDGE;
          edge_from_next = 6'(pt_q[PTW-1:VW+SW]);
          edge_to_next   = 6'(pt_q[VW+SW-1:SW]);
          edge_slot_next = 3'(pt_q[SW-1:0]);
          last_next      = (cnt == '0);
          state_next     = (cnt == '0) ? bfs_pkg::S_IDLE : bfs_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_next = bfs_pkg::S_IDLE;
      end
    endcase
  end

  assign nb_rd_addr = NAW'(((state == bfs_pkg::S_DEG) ? q_q : u_r) * MAX_DEGREE)
                      + NAW'(nb_rd_slot);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: register, degree valid bits, visited marks, counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= 7'(MAX_VERTICES);
      deg_valid <= '0;
      visited   <= '0;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      slot      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcount <= cfg_clamped;
      end
      if (deg_clear) begin
        deg_valid <= '0;
      end else if (deg_wr_en) begin
        deg_valid[deg_wr_addr] <= 1'b1;
      end
      if (search_start) begin
        visited <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_idx;
        head    <= '0;
        tail    <= QW'(1);
      end else begin
        if (state == bfs_pkg::S_NB && visit) begin
          visited[nb_q] <= 1'b1;
          tail          <= QW'(tail + 1'b1);
        end
        if (q_rd_en) begin
          head <= QW'(head + 1'b1);
        end
      end
      if (state == bfs_pkg::S_DEG) begin
        slot <= '0;
      end else if (state == bfs_pkg::S_NB) begin
        slot <= DCW'(slot + 1'b1);
      end
      if (state == bfs_pkg::S_CHECK) begin
        cnt <= '0;
      end else if (pt_wr_en) begin
        cnt <= VW'(cnt + 1'b1);
      end else if (pt_rd_en) begin
        cnt <= VW'(cnt - 1'b1);
      end
    end
  end

  // Request capture and search working values.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= bfs_pkg::op_t'(operation);
      a_r  <= from_vertex;
      b_r  <= to_vertex;
    end
    if (state == bfs_pkg::S_DEQ) begin
      u_r <= q_q;
    end
    if (state == bfs_pkg::S_DEG) begin
      deg_r <= deg_eff;
    end
    if (state == bfs_pkg::S_CHECK) begin
      walk_v <= b_idx;
    end else if (state == bfs_pkg::S_WALK) begin
      walk_v <= pa_q[PW-1:SW];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= status_next;
      edge_from <= edge_from_next;
      edge_to   <= edge_to_next;
      edge_slot <= edge_slot_next;
      last      <= last_next;
    end
  end

  // Degree memory.
  always_ff @(posedge clk) begin
    if (deg_wr_en) begin
      deg_mem[deg_wr_addr] <= deg_wr_data;
    end
    if (deg_rd_en) begin
      deg_q   <= deg_mem[deg_rd_addr];
      deg_hit <= deg_valid[deg_rd_addr];
    end
  end

  // Neighbor memory.
  always_ff @(posedge clk) begin
    if (nb_wr_en) begin
      nb_mem[nb_wr_addr] <= b_idx;
    end
    if (nb_rd_en) begin
      nb_q <= nb_mem[nb_rd_addr];
    end
  end

  // Parent memory.
  always_ff @(posedge clk) begin
    if (pa_wr_en) begin
      pa_mem[pa_wr_addr] <= pa_wr_data;
    end
    if (pa_rd_en) begin
      pa_q <= pa_mem[pa_rd_addr];
    end
  end

  // Search queue memory.
  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      q_mem[q_wr_addr] <= q_wr_data;
    end
    if (q_rd_en) begin
      q_q <= q_mem[q_rd_addr];
    end
  end

  // Path stack memory, filled finish to start and drained start to finish.
  always_ff @(posedge clk) begin
    if (pt_wr_en) begin
      pt_mem[pt_wr_addr] <= pt_wr_data;
    end
    if (pt_rd_en) begin
      pt_q <= pt_mem[pt_rd_addr];
    end
  end

  // The queue read pointer never passes the write pointer.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed tail");

  // During a search the number of visited marks equals the queue write count.
  a_visit_count: assert property (@(posedge clk) disable iff (rst)
    (state == bfs_pkg::S_POP || state == bfs_pkg::S_DEQ ||
     state == bfs_pkg::S_DEG || state == bfs_pkg::S_NB) |->
    $countones(visited) == int'(tail))
    else $error("visited marks disagree with queue length");

  // The vertex count register stays in its legal range.
  a_vcount_range: assert property (@(posedge clk) disable iff (rst)
    vcount >= 7'd1 && vcount <= 7'(MAX_VERTICES))
    else $error("vertex count out of range");

  // An adjacency scan never runs past the maximum list length.
  a_deg_bound: assert property (@(posedge clk) disable iff (rst)
    state == bfs_pkg::S_NB |-> deg_r <= DCW'(MAX_DEGREE) && slot < deg_r)
    else $error("adjacency scan out of bounds");

endmodule

`default_nettype wire

>>> tb/bfs_path_finder_tb.sv
// Self-checking testbench for the breadth-first path finder.
// Predicts edits and queries in a scoreboard class; tasks drive the request
// and register channels, a process the result ready. Depends on bfs_pkg.
`default_nettype none

module bfs_path_finder_tb;

  localparam int NV = 64;
  localparam int ND = 8;
  localparam int STALL_LIMIT = 200000;
  // Operation code with no meaning; the block ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] efrom;
    logic [5:0] eto;
    logic [2:0] eslot;
    logic       elast;
  } path_result_t;

  // Graph predictor and store of expected results.
  class path_scoreboard;
    int unsigned vcount;
    logic [3:0] degree[NV];
    logic [5:0] adjacency[NV*ND];
    logic [6:0] parent_v[NV];
    logic [2:0] parent_s[NV];
    path_result_t pending[$];
    int errors;

    function void init();
      vcount = NV;
      foreach (degree[i]) degree[i] = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void set_vertex_count(logic [6:0] value);
      vcount = value;
      if (vcount < 1) vcount = 1;
      if (vcount > NV) vcount = NV;
    endfunction

    function void push_single(bfs_pkg::status_t st);
      path_result_t r;
      r = '0;
      r.status = st;
      r.elast = 1'b1;
      pending.insert(pending.size(), r);
    endfunction

    function void search(int start, int finish);
      int q[$];
      bit seen[NV];
      int path[$];
      int u, w, v;
      path_result_t r;
      if (start == finish) begin
        push_single(bfs_pkg::ST_DONE);
        return;
      end
      foreach (seen[i]) seen[i] = 0;
      seen[start] = 1;
      q.insert(q.size(), start);
      while (q.size() > 0) begin
        u = q.pop_front();
        if (u == finish) break;
        for (int i = 0; i < degree[u] && i < ND; i++) begin
          w = adjacency[u*ND+i];
          if (w >= vcount) continue;
          if (!seen[w]) begin
            seen[w] = 1;
            parent_v[w] = u;
            parent_s[w] = i;
            q.insert(q.size(), w);
          end
        end
      end
      if (!seen[finish]) begin
        push_single(bfs_pkg::ST_NO_PATH);
        return;
      end
      v = finish;
      while (v != start && path.size() < NV - 1) begin
        path.push_front(v);
        v = parent_v[v] % NV;
      end
      foreach (path[i]) begin
        r.status = bfs_pkg::ST_EDGE;
        r.efrom = parent_v[path[i]][5:0];
        r.eto = path[i];
        r.eslot = parent_s[path[i]];
        r.elast = (i == path.size() - 1);
        pending.insert(pending.size(), r);
      end
    endfunction

    // Note one accepted request.
    function void note_request(logic [1:0] op, logic [5:0] a, logic [5:0] b);
      if (op == bfs_pkg::OP_CLEAR) begin
        foreach (degree[i]) degree[i] = 0;
        push_single(bfs_pkg::ST_DONE);
      end else if (op == OP_UNUSED) begin
        return;
      end else if (a >= vcount || b >= vcount) begin
        push_single(bfs_pkg::ST_BAD);
      end else if (op == bfs_pkg::OP_ADD) begin
        if (degree[a] >= ND) push_single(bfs_pkg::ST_FULL);
        else begin
          adjacency[a*ND+degree[a]] = b;
          degree[a]++;
          push_single(bfs_pkg::ST_DONE);
        end
      end else begin
        search(a, b);
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(path_result_t got);
      path_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status)
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
      if (got.efrom !== exp_r.efrom)
        $display("%0t: edge_from exp %0d got %0d", $time, exp_r.efrom, got.efrom);
      if (got.eto !== exp_r.eto)
        $display("%0t: edge_to exp %0d got %0d", $time, exp_r.eto, got.eto);
      if (got.eslot !== exp_r.eslot)
        $display("%0t: edge_slot exp %0d got %0d", $time, exp_r.eslot, got.eslot);
      if (got.elast !== exp_r.elast)
        $display("%0t: last exp %0d got %0d", $time, exp_r.elast, got.elast);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [1:0] operation;
  logic [5:0] from_vertex, to_vertex, edge_from, edge_to;
  logic [2:0] status, edge_slot;
  logic last;
  logic [6:0] cfg_data;

  path_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int hold_off;
  int stall_cycles;
  int cur_vc;

  bfs_path_finder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .from_vertex(from_vertex), .to_vertex(to_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .edge_from(edge_from), .edge_to(edge_to),
    .edge_slot(edge_slot), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Accept results and check them at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({status, edge_from, edge_to, edge_slot, last});
  end

  // Receiver readiness, with an optional long hold-off.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no accepted transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready) || hold_off > 0)
      stall_cycles <= 0;
    else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("bfs_path_finder verification failed");
        $finish;
      end
    end
  end

  // Offer one request and wait for its acceptance.
  task automatic send_request(logic [1:0] op, logic [5:0] a, logic [5:0] b);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    from_vertex = a;
    to_vertex = b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, a, b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Write the vertex count register while the block is idle.
  task automatic write_vertex_count(logic [6:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_vertex_count(value);
    cur_vc = sb.vcount;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [5:0] pick_vertex();
    if ($urandom_range(19) == 0) return $urandom_range(63);
    return $urandom_range(cur_vc - 1);
  endfunction

  // Random phase: mostly edges and queries within the active vertices.
  task automatic random_phase(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 3) send_request(bfs_pkg::OP_CLEAR, $urandom, $urandom);
      else if (k < 5) send_request(OP_UNUSED, $urandom, $urandom);
      else if (k < 60) send_request(bfs_pkg::OP_ADD, pick_vertex(), pick_vertex());
      else send_request(bfs_pkg::OP_FIND, pick_vertex(), pick_vertex());
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    rst = 1'b1;
    in_valid = 1'b0; operation = '0; from_vertex = '0; to_vertex = '0;
    cfg_valid = 1'b0; cfg_data = '0; out_ready = 1'b0;
    hold_off = 0; stall_cycles = 0; cur_vc = NV;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a chain through the extremes, full list, bad vertices.
    send_request(bfs_pkg::OP_ADD, 0, 63);
    send_request(bfs_pkg::OP_ADD, 63, 62);
    send_request(bfs_pkg::OP_ADD, 62, 0);
    send_request(bfs_pkg::OP_FIND, 0, 62);
    send_request(bfs_pkg::OP_FIND, 62, 63);
    send_request(bfs_pkg::OP_FIND, 5, 5);
    send_request(bfs_pkg::OP_FIND, 0, 7);
    for (int i = 0; i < 9; i++) send_request(bfs_pkg::OP_ADD, 21, 42);
    send_request(bfs_pkg::OP_FIND, 21, 42);
    send_request(OP_UNUSED, 63, 63);
    write_vertex_count(7'd40);
    send_request(bfs_pkg::OP_ADD, 45, 1);
    send_request(bfs_pkg::OP_FIND, 0, 62);
    write_vertex_count(7'd0);
    send_request(bfs_pkg::OP_FIND, 0, 0);
    send_request(bfs_pkg::OP_ADD, 0, 1);
    write_vertex_count(7'd127);
    send_request(bfs_pkg::OP_CLEAR, 63, 63);
    send_request(bfs_pkg::OP_FIND, 0, 62);

    // Small graph: long paths are likely.
    write_vertex_count(7'd12);
    send_idle_pct = 38; recv_idle_pct = 88;
    random_phase(130);

    // Receiver holds off while requests keep coming.
    write_vertex_count(7'd64);
    send_idle_pct = 88; recv_idle_pct = 38;
    hold_off = 3000;
    random_phase(130);

    write_vertex_count(7'd1);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(10);
    write_vertex_count(7'd20);
    random_phase(120);

    wait_drained();
    if (sb.errors == 0)
      $display("bfs_path_finder verification clean");
    else
      $display("bfs_path_finder verification failed");
    $finish;
  end
endmodule

`default_nettype wire
